/* design/ikht_pkg.sv */
// ----------------------------------------------------------------------------
// ikht_pkg - shared types and constants of the integer-key hash table
// Table geometry, response codes, controller states and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package ikht_pkg;

  // Number of slots; slot index arithmetic wraps by truncation, so this is a
  // power of two.
  localparam int CAPACITY = 256;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int KEY_W    = 32;
  localparam int VAL_W    = 16;
  localparam int CNT_W    = 9;
  localparam int CODE_W   = 3;

  localparam logic [KEY_W-1:0] MIX_MUL = 32'h045D_9F3B;
  localparam int               MIX_SHIFT = 16;

  typedef enum logic [CODE_W-1:0] {
    RSP_HIT      = 3'd0,
    RSP_MISS     = 3'd1,
    RSP_INSERTED = 3'd2,
    RSP_PRESENT  = 3'd3,
    RSP_FULL     = 3'd4
  } rsp_code_t;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b000_0001,
    ST_MIX1 = 7'b000_0010,
    ST_MIX2 = 7'b000_0100,
    ST_HOME = 7'b000_1000,
    ST_READ = 7'b001_0000,
    ST_CMP  = 7'b010_0000,
    ST_RESP = 7'b100_0000
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic      load_req;
    logic      mix1_en;
    logic      mix2_en;
    logic      home_en;
    logic      rd_en;
    logic      step_en;
    logic      rsp_load;
    rsp_code_t rsp_code;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_insert;
    logic tbl_empty;
    logic occupied;
    logic key_match;
    logic last_probe;
    logic out_free;
  } dp_stat_t;

endpackage

/* design/ikht_if.sv */
// ----------------------------------------------------------------------------
// ikht_if - request and response channels of the hash table
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface ikht_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic signed [31:0] key;
  logic [15:0] value_ref;

  modport source (output valid, req_type, key, value_ref, input ready);
  modport sink   (input valid, req_type, key, value_ref, output ready);
endinterface

interface ikht_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] found_value;
  logic [8:0]  entry_count;

  modport source (output valid, status, found_value, entry_count, input ready);
  modport sink   (input valid, status, found_value, entry_count, output ready);
endinterface

/* design/ikht_dp.sv */
// ----------------------------------------------------------------------------
// ikht_dp - hash table datapath
// Request registers, two-stage key mix, slot memories with occupied flags,
// probe counter, entry counter and the response register.
// ----------------------------------------------------------------------------
module ikht_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ikht_pkg::dp_cmd_t                   cmd,
  output ikht_pkg::dp_stat_t                  stat,
  input  logic                                req_type,
  input  logic signed [ikht_pkg::KEY_W-1:0]   key,
  input  logic [ikht_pkg::VAL_W-1:0]          value_ref,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ikht_pkg::CODE_W-1:0]         out_status,
  output logic [ikht_pkg::VAL_W-1:0]          out_found_value,
  output logic [ikht_pkg::CNT_W-1:0]          out_entry_count
);

  logic                               insert_r;
  logic [ikht_pkg::KEY_W-1:0]         key_r;
  logic [ikht_pkg::VAL_W-1:0]         val_r;
  logic [ikht_pkg::KEY_W-1:0]         h1_r;
  logic [ikht_pkg::KEY_W-1:0]         h2_r;
  logic [ikht_pkg::KEY_W-1:0]         x1;
  logic [ikht_pkg::KEY_W-1:0]         x2;
  logic [ikht_pkg::KEY_W-1:0]         x3;
  logic [ikht_pkg::IDX_W-1:0]         idx_r;
  logic [ikht_pkg::IDX_W-1:0]         probe_r;
  logic [ikht_pkg::KEY_W-1:0]         key_mem [ikht_pkg::CAPACITY];
  logic [ikht_pkg::VAL_W-1:0]         val_mem [ikht_pkg::CAPACITY];
  logic [ikht_pkg::CAPACITY-1:0]      occ_r;
  logic [ikht_pkg::KEY_W-1:0]         key_rd_r;
  logic [ikht_pkg::VAL_W-1:0]         val_rd_r;
  logic                               occ_rd_r;
  logic [ikht_pkg::CNT_W-1:0]         cnt_r;
  logic [ikht_pkg::CNT_W-1:0]         cnt_nxt;
  logic                               wr_en;
  logic                               out_valid_r;
  logic [ikht_pkg::CODE_W-1:0]        out_status_r;
  logic [ikht_pkg::VAL_W-1:0]         out_found_r;
  logic [ikht_pkg::CNT_W-1:0]         out_cnt_r;

  // xorshift folds ahead of each multiply and before the slot index
  assign x1 = key_r ^ (key_r >> ikht_pkg::MIX_SHIFT);
  assign x2 = h1_r ^ (h1_r >> ikht_pkg::MIX_SHIFT);
  assign x3 = h2_r ^ (h2_r >> ikht_pkg::MIX_SHIFT);

  assign wr_en   = cmd.rsp_load && (cmd.rsp_code == ikht_pkg::RSP_INSERTED);
  assign cnt_nxt = wr_en ? cnt_r + ikht_pkg::CNT_W'(1) : cnt_r;

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      insert_r <= req_type;
      key_r    <= key;
      val_r    <= value_ref;
    end
    if (cmd.mix1_en) begin
      h1_r <= x1 * ikht_pkg::MIX_MUL;
    end
    if (cmd.mix2_en) begin
      h2_r <= x2 * ikht_pkg::MIX_MUL;
    end
    if (cmd.home_en) begin
      idx_r   <= x3[ikht_pkg::IDX_W-1:0];
      probe_r <= '0;
    end else if (cmd.step_en) begin
      idx_r   <= idx_r + ikht_pkg::IDX_W'(1);
      probe_r <= probe_r + ikht_pkg::IDX_W'(1);
    end
  end

  // Slot memories: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[idx_r] <= key_r;
      val_mem[idx_r] <= val_r;
    end
    if (cmd.rd_en) begin
      key_rd_r <= key_mem[idx_r];
      val_rd_r <= val_mem[idx_r];
      occ_rd_r <= occ_r[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) begin
        occ_r[idx_r] <= 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.rsp_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rsp_load) begin
      out_status_r <= cmd.rsp_code;
      out_found_r  <= (cmd.rsp_code == ikht_pkg::RSP_HIT) ? val_rd_r : '0;
      out_cnt_r    <= cnt_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_value = out_found_r;
  assign out_entry_count = out_cnt_r;

  assign stat.is_insert  = insert_r;
  assign stat.tbl_empty  = (cnt_r == '0);
  assign stat.occupied   = occ_rd_r;
  assign stat.key_match  = (key_rd_r == key_r);
  assign stat.last_probe = (probe_r == ikht_pkg::IDX_W'(ikht_pkg::CAPACITY - 1));
  assign stat.out_free   = !out_valid_r || out_ready;

endmodule

/* design/ikht_ctrl.sv */
// ----------------------------------------------------------------------------
// ikht_ctrl - hash table controller
// Sequences accept, key mix, home slot, probe loop and response.
// ----------------------------------------------------------------------------
module ikht_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output ikht_pkg::dp_cmd_t   cmd,
  input  ikht_pkg::dp_stat_t  stat,
  output ikht_pkg::state_t    state
);

  ikht_pkg::state_t    state_r;
  ikht_pkg::state_t    state_nxt;
  ikht_pkg::rsp_code_t code_r;
  ikht_pkg::rsp_code_t code_nxt;

  always_comb begin
    state_nxt    = state_r;
    code_nxt     = code_r;
    cmd          = '0;
    cmd.rsp_code = code_r;
    case (state_r)
      ikht_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = ikht_pkg::ST_MIX1;
        end
      end
      ikht_pkg::ST_MIX1: begin
        // empty table: lookup misses without probing
        if (!stat.is_insert && stat.tbl_empty) begin
          code_nxt  = ikht_pkg::RSP_MISS;
          state_nxt = ikht_pkg::ST_RESP;
        end else begin
          cmd.mix1_en = 1'b1;
          state_nxt   = ikht_pkg::ST_MIX2;
        end
      end
      ikht_pkg::ST_MIX2: begin
        cmd.mix2_en = 1'b1;
        state_nxt   = ikht_pkg::ST_HOME;
      end
      ikht_pkg::ST_HOME: begin
        cmd.home_en = 1'b1;
        state_nxt   = ikht_pkg::ST_READ;
      end
      ikht_pkg::ST_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = ikht_pkg::ST_CMP;
      end
      ikht_pkg::ST_CMP: begin
        if (!stat.occupied) begin
          code_nxt  = stat.is_insert ? ikht_pkg::RSP_INSERTED : ikht_pkg::RSP_MISS;
          state_nxt = ikht_pkg::ST_RESP;
        end else if (stat.key_match) begin
          code_nxt  = stat.is_insert ? ikht_pkg::RSP_PRESENT : ikht_pkg::RSP_HIT;
          state_nxt = ikht_pkg::ST_RESP;
        end else if (stat.last_probe) begin
          code_nxt  = stat.is_insert ? ikht_pkg::RSP_FULL : ikht_pkg::RSP_MISS;
          state_nxt = ikht_pkg::ST_RESP;
        end else begin
          cmd.step_en = 1'b1;
          state_nxt   = ikht_pkg::ST_READ;
        end
      end
      ikht_pkg::ST_RESP: begin
        // hold until the response register can take the beat
        if (stat.out_free) begin
          cmd.rsp_load = 1'b1;
          state_nxt    = ikht_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ikht_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ikht_pkg::ST_IDLE;
      code_r  <= ikht_pkg::RSP_MISS;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
    end
  end

  assign in_ready = (state_r == ikht_pkg::ST_IDLE);
  assign state    = state_r;

endmodule

/* design/integer_key_hash_table_unit.sv */
// Probes: a request makes 1..256 probes; a lookup on an empty table makes none
//   and skips the key mix.
// Throughput: one request at a time; every probe is a slot memory read followed
//   by a compare, which sets the pace.
// Reset: synchronous, active low; clears the occupied flags, count and control.
// ----------------------------------------------------------------------------
// integer_key_hash_table_unit - open-addressing hash table, linear probing
// Maps a signed 32-bit key to a 16-bit value handle in 256 slots. The home
// slot is a multiply-xorshift mix of the key; probing walks slots with wrap.
// ----------------------------------------------------------------------------
module integer_key_hash_table_unit (
  input  logic         clk,
  input  logic         rst_n,
  ikht_req_if.sink     in_req,
  ikht_rsp_if.source   out_rsp
);

  ikht_pkg::dp_cmd_t  cmd;
  ikht_pkg::dp_stat_t stat;
  ikht_pkg::state_t   state;
  logic               in_ready;

  // Controller: one request in flight, from the request beat to the
  // response register load.
  ikht_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat),
    .state    (state)
  );

  // Datapath: key mix, slot memories, counters and the response register.
  // The response register frees the controller, so a new request beat can
  // be taken while the last response still waits for its sink.
  ikht_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .req_type        (in_req.req_type),
    .key             (in_req.key),
    .value_ref       (in_req.value_ref),
    .out_valid       (out_rsp.valid),
    .out_ready       (out_rsp.ready),
    .out_status      (out_rsp.status),
    .out_found_value (out_rsp.found_value),
    .out_entry_count (out_rsp.entry_count)
  );

  assign in_req.ready = in_ready;

  // A request beat starts work: no second beat in the next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_req.valid && in_req.ready) |=> !in_req.ready)
    else $error("request taken while previous one in flight");

  // Only a hit carries a handle
  a_found_only_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_rsp.valid && (out_rsp.status != ikht_pkg::RSP_HIT))
      |-> (out_rsp.found_value == '0))
    else $error("handle on a non-hit response");

  // Count never exceeds the table size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid |-> (out_rsp.entry_count <= ikht_pkg::CNT_W'(ikht_pkg::CAPACITY)))
    else $error("entry count beyond capacity");

  // Response load happens only from the response state
  a_load_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rsp_load |-> (state == ikht_pkg::ST_RESP) && stat.out_free)
    else $error("response loaded outside response state");

endmodule

/* tb/tb_integer_key_hash_table_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_key_hash_table_unit - self-checking bench of the hash table
// Drives lookups and inserts through the request channel and predicts every
// response from a behavioral copy of the table. Traffic moves the table from
// empty through clustered mid load to completely full. Both channels idle at
// random.
// ----------------------------------------------------------------------------
module tb_integer_key_hash_table_unit;

  localparam int STALL_LIMIT = 4000;  // cycles with no beat on either side
  localparam int DRAIN_WAIT  = 600;   // beyond a full-table walk

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_INSERT = 1'b1
  } op_t;

  typedef struct {
    op_t         op;
    logic [31:0] key;
    logic [15:0] value_ref;
  } req_t;

  typedef struct {
    ikht_pkg::rsp_code_t status;
    logic [15:0]         found_value;
    logic [8:0]          entry_count;
  } rsp_t;

  logic clk = 1'b0;
  logic rst_n;

  ikht_req_if req_ch ();
  ikht_rsp_if rsp_ch ();

  integer_key_hash_table_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch)
  );

  always #5 clk = ~clk;

  // Shadow copy of the table
  logic [31:0] slot_key  [ikht_pkg::CAPACITY];
  logic [15:0] slot_val  [ikht_pkg::CAPACITY];
  bit          slot_used [ikht_pkg::CAPACITY];
  int unsigned used_slots = 0;

  // Requests waiting to go out, responses the table still owes
  req_t req_q[$];
  rsp_t table_rsp_q[$];

  // Keys the stimulus has placed in the table, as far as it can tell
  logic [31:0] placed_keys[$];
  bit          known_keys[bit [31:0]];

  int n_errors   = 0;
  int idle_pct   = 25;
  int gap_left   = 0;
  int stall_left = 0;
  int no_beat_cycles = 0;
  req_t on_wire;

  // Home slot: multiply-xorshift mix; capacity is a power of two, so the
  // modulo is the low index bits.
  function automatic logic [ikht_pkg::IDX_W-1:0] home_slot(logic [31:0] k);
    logic [31:0] h;
    h = k;
    h = ((h >> ikht_pkg::MIX_SHIFT) ^ h) * ikht_pkg::MIX_MUL;
    h = ((h >> ikht_pkg::MIX_SHIFT) ^ h) * ikht_pkg::MIX_MUL;
    h = (h >> ikht_pkg::MIX_SHIFT) ^ h;
    return h[ikht_pkg::IDX_W-1:0];
  endfunction

  // Walk the probe sequence of one request, update the shadow table and
  // return the response it must produce.
  function automatic rsp_t probe_and_update(req_t r);
    rsp_t                        o;
    logic [ikht_pkg::IDX_W-1:0]  idx;
    bit                          done;
    idx           = home_slot(r.key);
    o.status      = (r.op == OP_INSERT) ? ikht_pkg::RSP_FULL : ikht_pkg::RSP_MISS;
    o.found_value = '0;
    done          = 1'b0;
    // An empty table answers a lookup without probing
    if (r.op == OP_INSERT || used_slots != 0) begin
      for (int p = 0; p < ikht_pkg::CAPACITY && !done; p++) begin
        if (!slot_used[idx]) begin
          if (r.op == OP_INSERT) begin
            slot_key[idx]  = r.key;
            slot_val[idx]  = r.value_ref;
            slot_used[idx] = 1'b1;
            used_slots++;
            o.status = ikht_pkg::RSP_INSERTED;
          end
          done = 1'b1;
        end else if (slot_key[idx] == r.key) begin
          if (r.op == OP_INSERT) begin
            o.status = ikht_pkg::RSP_PRESENT;
          end else begin
            o.status      = ikht_pkg::RSP_HIT;
            o.found_value = slot_val[idx];
          end
          done = 1'b1;
        end else begin
          idx = idx + 1'b1;  // wraps from the last slot to slot 0
        end
      end
    end
    o.entry_count = 9'(used_slots);
    return o;
  endfunction

  // Stimulus helpers

  function automatic logic [31:0] fresh_key();
    logic [31:0] k;
    do k = $urandom(); while (known_keys.exists(k));
    return k;
  endfunction

  // Unused key whose home slot is idx; builds clusters and wrap-around runs
  function automatic logic [31:0] key_homed_at(logic [ikht_pkg::IDX_W-1:0] idx);
    logic [31:0] k;
    do k = $urandom(); while (home_slot(k) != idx || known_keys.exists(k));
    return k;
  endfunction

  function automatic logic [31:0] any_placed();
    return placed_keys[$urandom_range(0, placed_keys.size() - 1)];
  endfunction

  task automatic queue_req(op_t op, logic [31:0] k, logic [15:0] v);
    req_t r;
    r.op        = op;
    r.key       = k;
    r.value_ref = v;
    req_q.push_back(r);
    if (op == OP_INSERT && !known_keys.exists(k) &&
        placed_keys.size() < ikht_pkg::CAPACITY) begin
      known_keys[k] = 1'b1;
      placed_keys.push_back(k);
    end
  endtask

  // Mixed lookups and inserts over known, colliding and fresh keys; new keys
  // go in only while fewer than fill_cap are placed.
  task automatic mixed_traffic(int n, int fill_cap);
    op_t         op;
    logic [31:0] k;
    int          roll;
    for (int i = 0; i < n; i++) begin
      op   = $urandom_range(0, 1) ? OP_INSERT : OP_LOOKUP;
      roll = $urandom_range(0, 9);
      if (placed_keys.size() != 0 && roll < 5) begin
        k = any_placed();
      end else if (placed_keys.size() != 0 && roll < 7) begin
        k = key_homed_at(home_slot(any_placed()));
      end else begin
        k = fresh_key();
      end
      if (op == OP_INSERT && !known_keys.exists(k) && placed_keys.size() >= fill_cap) begin
        k = any_placed();
      end
      queue_req(op, k, 16'($urandom()));
    end
  endtask

  // Hold until every request is out and every response is back
  task automatic wait_drained();
    while (req_q.size() != 0 || req_ch.valid || table_rsp_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Request driver: record the beat that just moved, then present the next
  // request or insert an idle burst.
  always @(posedge clk) begin : drive_req
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        table_rsp_q.push_back(probe_and_update(on_wire));
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          req_ch.valid <= 1'b0;
        end else if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
          gap_left = $urandom_range(1, 12) - 1;
          req_ch.valid <= 1'b0;
        end else if (req_q.size() != 0) begin
          on_wire = req_q.pop_front();
          req_ch.valid     <= 1'b1;
          req_ch.req_type  <= on_wire.op;
          req_ch.key       <= on_wire.key;
          req_ch.value_ref <= on_wire.value_ref;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor: check each beat against the oldest owed response and
  // stall ready in random bursts.
  always @(posedge clk) begin : watch_rsp
    rsp_t want;
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (table_rsp_q.size() == 0) begin
          $error("response beat with no request outstanding: status %0d", rsp_ch.status);
          n_errors++;
        end else begin
          want = table_rsp_q.pop_front();
          if (rsp_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
            n_errors++;
          end
          if (rsp_ch.found_value !== want.found_value) begin
            $error("found_value: expected %0h, got %0h", want.found_value, rsp_ch.found_value);
            n_errors++;
          end
          if (rsp_ch.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count, rsp_ch.entry_count);
            n_errors++;
          end
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
        stall_left = $urandom_range(1, 12) - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: a silence on both channels far longer than a full-table walk
  // means a hang.
  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        no_beat_cycles <= 0;
      end else if (no_beat_cycles >= STALL_LIMIT) begin
        $display("tb_integer_key_hash_table_unit: errors");
        $finish;
      end else begin
        no_beat_cycles <= no_beat_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    logic [31:0] wrap_a, wrap_b, wrap_c, wrap_absent;
    rst_n            = 1'b0;
    req_ch.valid     = 1'b0;
    req_ch.req_type  = OP_LOOKUP;
    req_ch.key       = '0;
    req_ch.value_ref = '0;
    rsp_ch.ready     = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: lookups on the empty table, key and handle extremes,
    // re-insert of a present key, a cluster that wraps past the last slot.
    queue_req(OP_LOOKUP, 32'h0000_0000, 16'h0000);
    queue_req(OP_LOOKUP, 32'h8000_0000, 16'hFFFF);
    queue_req(OP_INSERT, 32'h8000_0000, 16'hFFFF);
    queue_req(OP_INSERT, 32'h7FFF_FFFF, 16'h0000);
    queue_req(OP_INSERT, 32'h0000_0000, 16'h0001);
    queue_req(OP_INSERT, 32'hFFFF_FFFF, 16'hAAAA);
    queue_req(OP_LOOKUP, 32'h8000_0000, 16'h0000);
    queue_req(OP_LOOKUP, 32'h7FFF_FFFF, 16'hFFFF);
    queue_req(OP_LOOKUP, 32'h0000_0000, 16'h0000);
    queue_req(OP_LOOKUP, 32'hFFFF_FFFF, 16'h0000);
    queue_req(OP_INSERT, 32'h8000_0000, 16'h1234);
    queue_req(OP_LOOKUP, 32'h8000_0000, 16'h0000);
    wrap_a = key_homed_at(ikht_pkg::IDX_W'(ikht_pkg::CAPACITY - 1));
    queue_req(OP_INSERT, wrap_a, 16'h5555);
    wrap_b = key_homed_at(ikht_pkg::IDX_W'(ikht_pkg::CAPACITY - 1));
    queue_req(OP_INSERT, wrap_b, 16'h0F0F);
    wrap_c = key_homed_at(ikht_pkg::IDX_W'(ikht_pkg::CAPACITY - 1));
    queue_req(OP_INSERT, wrap_c, 16'hF0F0);
    wrap_absent = key_homed_at(ikht_pkg::IDX_W'(ikht_pkg::CAPACITY - 1));
    queue_req(OP_LOOKUP, wrap_c, 16'h0000);
    queue_req(OP_LOOKUP, wrap_absent, 16'h0000);
    queue_req(OP_LOOKUP, fresh_key(), 16'h0000);

    // Hold the sender until the directed part is fully answered
    wait_drained();

    // Moderate load with clustering
    mixed_traffic(450, 200);
    wait_drained();

    // Fill the table to the last slot, with some lookups at high load
    idle_pct = 10;
    while (placed_keys.size() < ikht_pkg::CAPACITY) begin
      if ($urandom_range(0, 3) == 0) begin
        queue_req(OP_LOOKUP, $urandom_range(0, 1) ? any_placed() : fresh_key(),
                  16'($urandom()));
      end else begin
        queue_req(OP_INSERT, fresh_key(), 16'($urandom()));
      end
    end

    // Full table: full-wrap misses, rejected inserts, hits and re-inserts
    idle_pct = 25;
    mixed_traffic(100, ikht_pkg::CAPACITY + 1);
    wait_drained();

    // Closing stretch without idling on either side
    idle_pct = 0;
    mixed_traffic(60, ikht_pkg::CAPACITY);

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (n_errors == 0 && table_rsp_q.size() == 0) begin
      $display("tb_integer_key_hash_table_unit: clean");
    end else begin
      $display("tb_integer_key_hash_table_unit: errors");
    end
    $finish;
  end

endmodule
